### sv/evad_pkg.sv
package evad_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 41;
    localparam int SQ_W        = 31;
    localparam int THR_W       = 15;
    localparam int START_CNT_W = 8;
    localparam int IDLE_CNT_W  = 10;
    localparam int SPEECH_W    = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int MAX_FRAME_SAMPLES_DEF = 1024;

    localparam logic [THR_W-1:0]       START_THR_RST = 15'd220;
    localparam logic [THR_W-1:0]       IDLE_THR_RST  = 15'd90;
    localparam logic [START_CNT_W-1:0] START_CNT_RST = 8'd4;
    localparam logic [IDLE_CNT_W-1:0]  IDLE_CNT_RST  = 10'd35;
    localparam logic [SPEECH_W-1:0]    MAX_SPEECH_RST = 16'd400;

    localparam logic [CFG_IDX_W-1:0] REG_START_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_CNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_CNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEECH = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SPEAK = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_READY,
        ST_ACC,
        ST_LIM,
        ST_CLASS,
        ST_RESTART,
        ST_DROP
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic accum;
        logic limits;
        logic classify;
        logic restart;
        logic done_emit;
        logic clear_frame;
    } evad_cmd_t;

    typedef struct packed {
        logic phase_done;
        logic frame_last;
        logic out_free;
    } evad_sts_t;

endpackage

### sv/evad_ctrl.sv
module evad_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                mode,
    input  evad_pkg::evad_sts_t sts,
    output logic                in_stall,
    output evad_pkg::evad_cmd_t cmd
);

    evad_pkg::ctrl_state_t state_reg;
    evad_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= evad_pkg::ST_READY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            evad_pkg::ST_READY:
            begin
                if (in_valid)
                begin
                    priority if (mode)
                        state_next = evad_pkg::ST_RESTART;
                    else if (sts.phase_done)
                        state_next = evad_pkg::ST_DROP;
                    else
                        state_next = evad_pkg::ST_ACC;
                end
            end
            evad_pkg::ST_ACC:
            begin
                state_next = sts.frame_last ? evad_pkg::ST_LIM : evad_pkg::ST_READY;
            end
            evad_pkg::ST_LIM:
            begin
                state_next = evad_pkg::ST_CLASS;
            end
            evad_pkg::ST_CLASS, evad_pkg::ST_RESTART:
            begin
                if (sts.out_free)
                    state_next = evad_pkg::ST_READY;
            end
            evad_pkg::ST_DROP:
            begin
                if (!sts.frame_last || sts.out_free)
                    state_next = evad_pkg::ST_READY;
            end
            default:
            begin
                state_next = evad_pkg::ST_READY;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            evad_pkg::ST_READY:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            evad_pkg::ST_ACC:
            begin
                cmd.accum = 1'b1;
            end
            evad_pkg::ST_LIM:
            begin
                cmd.limits = 1'b1;
            end
            evad_pkg::ST_CLASS:
            begin
                cmd.classify = sts.out_free;
            end
            evad_pkg::ST_RESTART:
            begin
                cmd.restart = sts.out_free;
            end
            evad_pkg::ST_DROP:
            begin
                cmd.clear_frame = !sts.frame_last;
                cmd.done_emit   = sts.frame_last && sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

### sv/evad_dp.sv
module evad_dp #(
    parameter int MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [evad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [evad_pkg::SAMPLE_W-1:0]       sample,
    input  logic                                frame_last,
    input  evad_pkg::evad_cmd_t                 cmd,
    output evad_pkg::evad_sts_t                 sts,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [1:0]                          detector_state,
    output logic                                frame_loud,
    output logic                                frame_quiet,
    output logic [evad_pkg::SPEECH_W-1:0]       utterance_frames
);

    localparam int CntW = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int LimW = CntW + evad_pkg::SQ_W;
    localparam int CmpW = (LimW > evad_pkg::SUM_W) ? LimW : evad_pkg::SUM_W;
    localparam int SumW = evad_pkg::SUM_W;

    logic [evad_pkg::THR_W-1:0]       loud_level_reg;
    logic [evad_pkg::THR_W-1:0]       quiet_level_reg;
    logic [evad_pkg::START_CNT_W-1:0] start_cnt_reg;
    logic [evad_pkg::IDLE_CNT_W-1:0]  idle_cnt_reg;
    logic [evad_pkg::SPEECH_W-1:0]    max_speech_reg;

    logic [SumW-1:0]                  sum_reg;
    logic [SumW-1:0]                  sum_next;
    logic [CntW-1:0]                  cnt_reg;
    logic [CntW-1:0]                  cnt_next;
    evad_pkg::phase_t                 phase_reg;
    evad_pkg::phase_t                 phase_next;
    logic [evad_pkg::START_CNT_W-1:0] loud_run_reg;
    logic [evad_pkg::START_CNT_W-1:0] loud_run_next;
    logic [evad_pkg::IDLE_CNT_W-1:0]  quiet_run_reg;
    logic [evad_pkg::IDLE_CNT_W-1:0]  quiet_run_next;
    logic [evad_pkg::SPEECH_W-1:0]    speech_reg;
    logic [evad_pkg::SPEECH_W-1:0]    speech_next;
    logic                             last_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;

    logic [evad_pkg::SQ_W-1:0]        sq_reg;
    logic [evad_pkg::SQ_W-1:0]        s1sq_reg;
    logic [evad_pkg::SQ_W-1:0]        idsq_reg;
    logic [LimW-1:0]                  lim_loud_reg;
    logic [LimW-1:0]                  lim_quiet_reg;
    logic [1:0]                       res_state_reg;
    logic                             res_loud_reg;
    logic                             res_quiet_reg;
    logic [evad_pkg::SPEECH_W-1:0]    res_speech_reg;

    logic [evad_pkg::SAMPLE_W-1:0]    mag;
    logic [2*evad_pkg::SAMPLE_W-1:0]  mag_sq;
    logic [evad_pkg::SAMPLE_W-1:0]    s1;
    logic [2*evad_pkg::SAMPLE_W-1:0]  s1_sq;
    logic [2*evad_pkg::THR_W-1:0]     id_sq;
    logic [SumW:0]                    sum_add;
    logic                             loud;
    logic                             quiet;
    logic                             out_free;
    logic                             res_load;

    assign mag    = sample[evad_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
    assign mag_sq = mag * mag;
    assign s1     = {1'b0, loud_level_reg} + 1'b1;
    assign s1_sq  = s1 * s1;
    assign id_sq  = quiet_level_reg * quiet_level_reg;
    assign sum_add = {1'b0, sum_reg} + (SumW + 1)'(sq_reg);
    assign loud   = CmpW'(sum_reg) >= CmpW'(lim_loud_reg);
    assign quiet  = CmpW'(sum_reg) < CmpW'(lim_quiet_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign res_load = cmd.classify || cmd.restart || cmd.done_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loud_level_reg  <= evad_pkg::START_THR_RST;
            quiet_level_reg <= evad_pkg::IDLE_THR_RST;
            start_cnt_reg   <= evad_pkg::START_CNT_RST;
            idle_cnt_reg    <= evad_pkg::IDLE_CNT_RST;
            max_speech_reg  <= evad_pkg::MAX_SPEECH_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                evad_pkg::REG_START_THR:  loud_level_reg  <= cfg_data[evad_pkg::THR_W-1:0];
                evad_pkg::REG_IDLE_THR:   quiet_level_reg <= cfg_data[evad_pkg::THR_W-1:0];
                evad_pkg::REG_START_CNT:  start_cnt_reg   <= cfg_data[evad_pkg::START_CNT_W-1:0];
                evad_pkg::REG_IDLE_CNT:   idle_cnt_reg    <= cfg_data[evad_pkg::IDLE_CNT_W-1:0];
                evad_pkg::REG_MAX_SPEECH: max_speech_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        loud_run_next  = loud_run_reg;
        quiet_run_next = quiet_run_reg;
        speech_next    = speech_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.accum && (cnt_reg < CntW'(MAX_FRAME_SAMPLES)))
        begin
            sum_next = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.classify)
        begin
            sum_next = '0;
            cnt_next = '0;
            if (phase_reg == evad_pkg::PH_IDLE)
            begin
                if (!loud)
                    loud_run_next = '0;
                else if (loud_run_reg != '1)
                    loud_run_next = loud_run_reg + 1'b1;
                if (loud_run_next >= start_cnt_reg)
                begin
                    phase_next     = evad_pkg::PH_SPEAK;
                    loud_run_next  = '0;
                    quiet_run_next = '0;
                    speech_next    = '0;
                end
            end
            else
            begin
                if (speech_reg != '1)
                    speech_next = speech_reg + 1'b1;
                priority if (quiet)
                begin
                    if (quiet_run_reg != '1)
                        quiet_run_next = quiet_run_reg + 1'b1;
                end
                else if (loud)
                begin
                    quiet_run_next = '0;
                end
                if ((quiet_run_next >= idle_cnt_reg) || (speech_next >= max_speech_reg))
                begin
                    phase_next     = evad_pkg::PH_DONE;
                    quiet_run_next = '0;
                end
            end
        end

        if (cmd.restart)
        begin
            sum_next       = '0;
            cnt_next       = '0;
            phase_next     = evad_pkg::PH_IDLE;
            loud_run_next  = '0;
            quiet_run_next = '0;
            speech_next    = '0;
        end

        if (cmd.done_emit || cmd.clear_frame)
        begin
            sum_next = '0;
            cnt_next = '0;
        end

        if (res_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            phase_reg     <= evad_pkg::PH_IDLE;
            loud_run_reg  <= '0;
            quiet_run_reg <= '0;
            speech_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            loud_run_reg  <= loud_run_next;
            quiet_run_reg <= quiet_run_next;
            speech_reg    <= speech_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sq_reg   <= mag_sq[evad_pkg::SQ_W-1:0];
            last_reg <= frame_last;
        end
        if (cmd.accum)
        begin
            s1sq_reg <= s1_sq[evad_pkg::SQ_W-1:0];
            idsq_reg <= evad_pkg::SQ_W'(id_sq);
        end
        if (cmd.limits)
        begin
            lim_loud_reg  <= cnt_reg * s1sq_reg;
            lim_quiet_reg <= cnt_reg * idsq_reg;
        end
        if (res_load)
        begin
            res_state_reg  <= phase_next;
            res_loud_reg   <= cmd.classify && loud;
            res_quiet_reg  <= cmd.classify && quiet;
            res_speech_reg <= speech_next;
        end
    end

    assign sts.phase_done = (phase_reg == evad_pkg::PH_DONE);
    assign sts.frame_last = last_reg;
    assign sts.out_free   = out_free;

    assign out_valid        = out_valid_reg;
    assign detector_state   = res_state_reg;
    assign frame_loud       = res_loud_reg;
    assign frame_quiet      = res_quiet_reg;
    assign utterance_frames = res_speech_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(MAX_FRAME_SAMPLES))
        else $error("frame sample count beyond limit");

    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == evad_pkg::PH_DONE) |-> (sum_reg == '0 && cnt_reg == '0))
        else $error("frame energy held in done phase");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded over a pending word");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart |=> (phase_reg == evad_pkg::PH_IDLE && speech_reg == '0
                         && res_state_reg == 2'd0 && out_valid_reg))
        else $error("restart did not return to idle");

endmodule

### sv/energy_voice_activity_detector.sv
// channel  | handshake               | payload
// ---------+-------------------------+-----------------------------------------------
// in       | in_valid / in_stall     | mode, sample, frame_last
// out      | out_valid / out_stall   | detector_state, frame_loud, frame_quiet,
//          |                         | utterance_frames
// cfg      | cfg_write_en            | cfg_index, cfg_data
//
// A sample inside a frame is accepted (squared), then accumulated.
// A frame-end sample then forms the threshold products and the compare, and waits
// for the output register to be free before its result is loaded.
// Restart and done-phase words also wait for the output register when they give a result.
// The sequencer holds one word at a time.
// rst_n clears the sequencer, the frame sum and detector state and loads register defaults.
// A stalled result holds in the output register while the next words are taken.
module energy_voice_activity_detector #(
    parameter int MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [evad_pkg::SAMPLE_W-1:0]   sample,
    input  logic                            frame_last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      detector_state,
    output logic                            frame_loud,
    output logic                            frame_quiet,
    output logic [evad_pkg::SPEECH_W-1:0]   utterance_frames
);

    evad_pkg::evad_cmd_t cmd;
    evad_pkg::evad_sts_t sts;

    evad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    evad_dp #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample           (sample),
        .frame_last       (frame_last),
        .cmd              (cmd),
        .sts              (sts),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .detector_state   (detector_state),
        .frame_loud       (frame_loud),
        .frame_quiet      (frame_quiet),
        .utterance_frames (utterance_frames)
    );

endmodule

### verif/energy_vad_checker.sv
module energy_vad_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            mode,
    input  logic [evad_pkg::SAMPLE_W-1:0]   sample,
    input  logic                            frame_last,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [1:0]                      detector_state,
    input  logic                            frame_loud,
    input  logic                            frame_quiet,
    input  logic [evad_pkg::SPEECH_W-1:0]   utterance_frames,
    output int                              errors,
    output int                              pending,
    output int                              checked,
    output int                              speech_starts,
    output int                              speech_ends
);
    import evad_pkg::*;

    typedef struct packed {
        phase_t                state;
        logic                  loud;
        logic                  quiet;
        logic [SPEECH_W-1:0]   frames;
    } frame_verdict_t;

    localparam logic [SUM_W-1:0] SUM_SAT = '1;

    logic [THR_W-1:0]       loud_level = START_THR_RST;
    logic [THR_W-1:0]       quiet_level = IDLE_THR_RST;
    logic [START_CNT_W-1:0] start_cnt = START_CNT_RST;
    logic [IDLE_CNT_W-1:0]  idle_cnt = IDLE_CNT_RST;
    logic [SPEECH_W-1:0]    max_speech = MAX_SPEECH_RST;

    logic [SUM_W-1:0]       energy = '0;
    int unsigned            frame_len = 0;
    phase_t                 phase = PH_IDLE;
    logic [START_CNT_W-1:0] loud_run = '0;
    logic [IDLE_CNT_W-1:0]  quiet_run = '0;
    logic [SPEECH_W-1:0]    speech_len = '0;

    frame_verdict_t verdicts_due[$];
    int err_n = 0;
    int checked_n = 0;
    int starts_n = 0;
    int ends_n = 0;

    function automatic bit advance_detector(input logic restart, input logic [SAMPLE_W-1:0] pcm,
                                            input logic last, output frame_verdict_t v);
        logic [16:0] mag;
        logic [63:0] sq;
        logic [63:0] total;
        logic [63:0] s1;
        logic [63:0] lim_loud;
        logic [63:0] lim_quiet;
        bit          loud;
        bit          quiet;
        v = '0;
        if (restart)
        begin
            energy = '0;
            frame_len = 0;
            phase = PH_IDLE;
            loud_run = '0;
            quiet_run = '0;
            speech_len = '0;
            v.state = PH_IDLE;
            return 1'b1;
        end
        if (phase == PH_DONE)
        begin
            energy = '0;
            frame_len = 0;
            if (!last)
                return 1'b0;
            v.state = PH_DONE;
            v.frames = speech_len;
            return 1'b1;
        end
        if (frame_len < MAX_FRAME_SAMPLES_DEF)
        begin
            mag = pcm[SAMPLE_W-1] ? 17'h10000 - {1'b0, pcm} : {1'b0, pcm};
            sq = 64'(mag) * 64'(mag);
            total = 64'(energy) + sq;
            energy = (total > 64'(SUM_SAT)) ? SUM_SAT : total[SUM_W-1:0];
            frame_len++;
        end
        if (!last)
            return 1'b0;

        s1 = 64'(loud_level) + 64'd1;
        lim_loud = 64'(frame_len) * s1 * s1;
        lim_quiet = 64'(frame_len) * 64'(quiet_level) * 64'(quiet_level);
        loud = 64'(energy) >= lim_loud;
        quiet = 64'(energy) < lim_quiet;
        energy = '0;
        frame_len = 0;

        if (phase == PH_IDLE)
        begin
            if (loud)
            begin
                if (loud_run != '1)
                    loud_run++;
            end
            else
                loud_run = '0;
            if (loud_run >= start_cnt)
            begin
                phase = PH_SPEAK;
                loud_run = '0;
                quiet_run = '0;
                speech_len = '0;
                starts_n++;
            end
        end
        else
        begin
            if (speech_len != '1)
                speech_len++;
            if (quiet)
            begin
                if (quiet_run != '1)
                    quiet_run++;
            end
            else if (loud)
                quiet_run = '0;
            if (quiet_run >= idle_cnt || speech_len >= max_speech)
            begin
                phase = PH_DONE;
                quiet_run = '0;
                ends_n++;
            end
        end
        v.state = phase;
        v.loud = loud;
        v.quiet = quiet;
        v.frames = speech_len;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_verdict_t v;
        frame_verdict_t want;
        if (!rst_n)
        begin
            loud_level = START_THR_RST;
            quiet_level = IDLE_THR_RST;
            start_cnt = START_CNT_RST;
            idle_cnt = IDLE_CNT_RST;
            max_speech = MAX_SPEECH_RST;
            energy = '0;
            frame_len = 0;
            phase = PH_IDLE;
            loud_run = '0;
            quiet_run = '0;
            speech_len = '0;
            verdicts_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_START_THR:  loud_level = cfg_data[THR_W-1:0];
                    REG_IDLE_THR:   quiet_level = cfg_data[THR_W-1:0];
                    REG_START_CNT:  start_cnt = cfg_data[START_CNT_W-1:0];
                    REG_IDLE_CNT:   idle_cnt = cfg_data[IDLE_CNT_W-1:0];
                    REG_MAX_SPEECH: max_speech = cfg_data[SPEECH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (advance_detector(mode, sample, frame_last, v))
                    verdicts_due.push_back(v);
            end
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    err_n++;
                    $display("%0t: unexpected result, expected none, %s %0d %0d %0d %0d",
                             $time, "actual state/loud/quiet/frames",
                             detector_state, frame_loud, frame_quiet, utterance_frames);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    checked_n++;
                    if (detector_state !== want.state)
                    begin
                        err_n++;
                        $display("%0t: detector_state expected %0d actual %0d",
                                 $time, want.state, detector_state);
                    end
                    if (frame_loud !== want.loud)
                    begin
                        err_n++;
                        $display("%0t: frame_loud expected %0b actual %0b",
                                 $time, want.loud, frame_loud);
                    end
                    if (frame_quiet !== want.quiet)
                    begin
                        err_n++;
                        $display("%0t: frame_quiet expected %0b actual %0b",
                                 $time, want.quiet, frame_quiet);
                    end
                    if (utterance_frames !== want.frames)
                    begin
                        err_n++;
                        $display("%0t: utterance_frames expected %0d actual %0d",
                                 $time, want.frames, utterance_frames);
                    end
                end
            end
            pending <= verdicts_due.size();
        end
        errors <= err_n;
        checked <= checked_n;
        speech_starts <= starts_n;
        speech_ends <= ends_n;
    end

endmodule

### verif/tb_energy_voice_activity_detector.sv
module tb_energy_voice_activity_detector;
    import evad_pkg::*;

    localparam int CLK_PERIOD = 12;

    typedef enum int {
        FK_LOUD,
        FK_QUIET,
        FK_EDGE,
        FK_NOISE
    } frame_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  mode = 1'b0;
    logic [SAMPLE_W-1:0]   sample = '0;
    logic                  frame_last = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            detector_state;
    logic                  frame_loud;
    logic                  frame_quiet;
    logic [SPEECH_W-1:0]   utterance_frames;

    int check_errors;
    int verdicts_pending;
    int results_checked;
    int speech_starts;
    int speech_ends;

    int send_idle_pct = 14;
    int recv_idle_pct = 70;
    int words_sent = 0;
    int frames_sent = 0;
    int restarts_sent = 0;
    int cur_start = START_THR_RST;
    int cur_idle = IDLE_THR_RST;
    int cur_start_cnt = START_CNT_RST;
    int cur_idle_cnt = IDLE_CNT_RST;
    bit hold_kick = 1'b0;

    energy_voice_activity_detector uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .sample           (sample),
        .frame_last       (frame_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .detector_state   (detector_state),
        .frame_loud       (frame_loud),
        .frame_quiet      (frame_quiet),
        .utterance_frames (utterance_frames)
    );

    energy_vad_checker vad_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .sample           (sample),
        .frame_last       (frame_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .detector_state   (detector_state),
        .frame_loud       (frame_loud),
        .frame_quiet      (frame_quiet),
        .utterance_frames (utterance_frames),
        .errors           (check_errors),
        .pending          (verdicts_pending),
        .checked          (results_checked),
        .speech_starts    (speech_starts),
        .speech_ends      (speech_ends)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(CLK_PERIOD * 600000);
        $display("%0t: run did not finish in time", $time);
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random stall, plus one long hold-off per kick
    initial
    begin
        int hold;
        bit seen;
        hold = 0;
        seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_kick != seen)
            begin
                seen = hold_kick;
                hold = 300;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // hold each word until accepted
    task automatic send_word(logic m, logic [SAMPLE_W-1:0] s, logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        sample <= s;
        frame_last <= l;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        if (m)
            restarts_sent++;
        else if (l)
            frames_sent++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic write_config(int st, int it, int sc, int ic, int ms);
        write_reg(REG_START_THR, st);
        write_reg(REG_IDLE_THR, it);
        write_reg(REG_START_CNT, sc);
        write_reg(REG_IDLE_CNT, ic);
        write_reg(REG_MAX_SPEECH, ms);
        cfg_write_en <= 1'b0;
        cur_start = st;
        cur_idle = it;
        cur_start_cnt = sc;
        cur_idle_cnt = ic;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(frame_kind_t kind);
        int mag;
        case (kind)
            FK_LOUD:  mag = $urandom_range(32768, cur_start + 1);
            FK_QUIET: mag = (cur_idle == 0) ? 0 : $urandom_range(cur_idle - 1, 0);
            FK_EDGE:
            begin
                case ($urandom_range(5))
                    0:       mag = cur_start;
                    1:       mag = cur_start + 1;
                    2:       mag = cur_idle;
                    3:       mag = (cur_idle > 0) ? cur_idle - 1 : 0;
                    4:       mag = 32768;
                    default: mag = 32767;
                endcase
            end
            default: return SAMPLE_W'($urandom);
        endcase
        if (mag == 32768)
            return 16'h8000;
        return $urandom_range(1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    function automatic int frame_size();
        return ($urandom_range(11) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 4);
    endfunction

    function automatic frame_kind_t any_kind();
        return frame_kind_t'($urandom_range(3));
    endfunction

    task automatic send_frame(int len, frame_kind_t kind);
        for (int i = 0; i < len; i++)
            send_word(1'b0, pick_sample(kind), i == len - 1);
    endtask

    task automatic send_restart();
        send_word(1'b1, SAMPLE_W'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic run_utterance();
        int n;
        n = (cur_start_cnt > 6) ? $urandom_range(1, 6) : cur_start_cnt + $urandom_range(0, 1);
        repeat (n) send_frame(frame_size(), ($urandom_range(9) == 0) ? FK_EDGE : FK_LOUD);
        repeat ($urandom_range(0, 3)) send_frame(frame_size(), any_kind());
        n = (cur_idle_cnt > 8) ? $urandom_range(1, 8) : cur_idle_cnt + $urandom_range(0, 1);
        repeat (n) send_frame(frame_size(), ($urandom_range(7) == 0) ? any_kind() : FK_QUIET);
        repeat ($urandom_range(0, 2)) send_frame(frame_size(), any_kind());
        if ($urandom_range(4) != 0)
            send_restart();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(3))
                0:       send_restart();
                1:       send_frame(frame_size(), FK_NOISE);
                2:       send_word(1'b0, SAMPLE_W'($urandom), 1'b0);
                default: send_frame(frame_size(), FK_EDGE);
            endcase
        end
    endtask

    task automatic choose_config(int seg);
        if (seg == 1)
            write_config(0, 32767, 1, 1, 1);
        else if (seg == 4)
            write_config(32767, 0, 255, 1023, 65535);
        else if (seg == 7)
            write_config(32767, 32767, 1, 1023, 65535);
        else
            write_config(($urandom_range(5) == 0) ? 0 : $urandom_range(40, 2500),
                         ($urandom_range(5) == 0) ? 0 : $urandom_range(20, 1500),
                         $urandom_range(1, 4),
                         $urandom_range(1, 6),
                         ($urandom_range(5) == 0) ? $urandom_range(20, 65535)
                                                  : $urandom_range(2, 14));
    endtask

    initial
    begin
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(1'b0, 16'h7FFF, 1'b0);
        send_word(1'b0, 16'h8000, 1'b1);
        send_word(1'b0, 16'h0000, 1'b1);
        send_word(1'b1, 16'hFFFF, 1'b0);
        drain_results();

        write_config(100, 200, 2, 2, 5);
        send_word(1'b0, 16'h8000, 1'b1);
        send_word(1'b0, 16'd150, 1'b1);
        send_word(1'b0, 16'h0000, 1'b0);
        send_word(1'b0, 16'hFFFF, 1'b0);
        send_word(1'b0, 16'h0001, 1'b1);
        send_word(1'b0, 16'hFF6A, 1'b1);
        send_word(1'b0, 16'h7FFF, 1'b0);
        send_word(1'b0, 16'h8001, 1'b1);
        send_word(1'b0, 16'h03E8, 1'b0);
        send_word(1'b1, 16'h8000, 1'b1);
        send_word(1'b0, 16'h1000, 1'b0);
        send_word(1'b1, 16'h0000, 1'b0);
        send_word(1'b0, 16'd100, 1'b1);
        send_word(1'b0, 16'd101, 1'b1);
        drain_results();

        write_config(100, 200, 0, 0, 0);
        send_word(1'b0, 16'h0005, 1'b1);
        send_word(1'b0, 16'h0005, 1'b1);
        send_word(1'b1, 16'h5A5A, 1'b1);

        for (int regime = 0; regime < 3; regime++)
        begin
            send_idle_pct = (regime == 0) ? 14 : (regime == 1) ? 70 : 0;
            recv_idle_pct = (regime == 0) ? 70 : (regime == 1) ? 14 : 0;
            for (int k = 0; k < 3; k++)
            begin
                drain_results();
                choose_config(regime * 3 + k);
                if (regime == 0 && k == 0)
                    hold_kick = ~hold_kick;
                target = words_sent + 40;
                if (regime == 2 && k == 1)
                begin
                    send_restart();
                    for (int i = 0; i < 1024; i++)
                        send_word(1'b0, pick_sample(FK_LOUD), 1'b0);
                    send_frame($urandom_range(2, 16), FK_NOISE);
                end
                while (words_sent < target)
                begin
                    if ($urandom_range(4) == 0)
                        send_noise();
                    else
                        run_utterance();
                end
            end
        end
        drain_results();

        $display("covered %0d words: %0d frame ends, %0d restarts, 11 register settings",
                 words_sent, frames_sent, restarts_sent);
        $display("checked %0d results; %0d utterances opened, %0d closed",
                 results_checked, speech_starts, speech_ends);
        if (verdicts_pending != 0)
            $display("%0t: %0d expected results never arrived", $time, verdicts_pending);
        if (check_errors == 0 && verdicts_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
